### hw/rtl/mrfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter package
// Shared types, codes and the CRC-16/Modbus byte fold used by the delimiter.
// ----------------------------------------------------------------------------
package mrfd_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned QtyLimW  = 7;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FcReadHolding  = 8'h03;
  localparam logic [7:0] FcReadInput    = 8'h04;
  localparam logic [7:0] FcExcHolding   = 8'h83;
  localparam logic [7:0] FcExcInput     = 8'h84;

  localparam logic [6:0] QtyLimReset    = 7'd125;
  localparam logic [7:0] CountLimReset  = 8'd250;

  localparam logic [7:0] ExcLen         = 8'd5;
  localparam logic [7:0] ReqLen         = 8'd8;
  localparam logic [7:0] MinJudgeLen    = 8'd4;
  localparam logic [7:0] RespOverhead   = 8'd5;
  localparam logic [7:0] SeenMax        = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_QTY = 1'b0,
    CFG_MAX_BC  = 1'b1
  } cfg_idx_e;

  // Kind of frame found in a window.
  typedef enum logic [1:0] {
    OUT_NONE      = 2'd0,
    OUT_EXCEPTION = 2'd1,
    OUT_REQUEST   = 2'd2,
    OUT_RESPONSE  = 2'd3
  } outcome_e;

  // Snapshot of a closed window, handed from the front to the back.
  typedef struct packed {
    logic [7:0]  seen;
    logic [7:0]  unit;
    logic [7:0]  code;
    logic [7:0]  count;
    logic [15:0] reg_word;
    logic [15:0] qty_word;
    logic        req_possible;
    logic        crc_at5;
    logic        crc_at8;
    logic        crc_atresp;
  } window_rec_t;

  // One result item.
  typedef struct packed {
    outcome_e    outcome;
    logic [7:0]  frame_length;
    logic [7:0]  unit_address;
    logic [7:0]  function_code;
    logic        crc_ok;
    logic [7:0]  exception_code;
    logic [15:0] start_register;
    logic [15:0] read_quantity;
    logic [7:0]  response_byte_count;
  } result_t;

  // Fold one byte into a CRC-16/Modbus, reflected, one bit per step.
  function automatic logic [15:0] crc_fold(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/modbus_rtu_frame_delimiter.sv
// Throughput: one byte item per cycle, sustained, with the output free.
// Two register stages lie between the byte that ends the buffer and its result
//   item (window queue, then output register).
// A window queue of QueueDepth entries lets the front end run on while the
//   output is stalled; input stalls only when that queue is full.
// Reset clears the window state and sets the limits to 125 and 250.
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter
// Finds exception, read request and read response frames in candidate
// windows of a sniffed Modbus RTU byte stream.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_delimiter #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mrfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    byte_value_i,
  input  wire logic                          window_start_i,
  input  wire logic                          buffer_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         outcome_o,
  output logic [7:0]                         frame_length_o,
  output logic [7:0]                         unit_address_o,
  output logic [7:0]                         function_code_o,
  output logic                               crc_ok_o,
  output logic [7:0]                         exception_code_o,
  output logic [15:0]                        start_register_o,
  output logic [15:0]                        read_quantity_o,
  output logic [7:0]                         response_byte_count_o
);

  logic                  accept;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  q_valid;
  mrfd_pkg::window_rec_t push_rec;
  mrfd_pkg::window_rec_t q_rec;
  mrfd_pkg::result_t     res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Window tracking per byte.
  mrfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .byte_value_i   (byte_value_i),
    .window_start_i (window_start_i),
    .buffer_end_i   (buffer_end_i),
    .push_o         (push),
    .rec_o          (push_rec)
  );

  // Closed windows waiting to be judged.
  mrfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .rec_o      (q_rec)
  );

  // Judgement and output register.
  mrfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign outcome_o             = res.outcome;
  assign frame_length_o        = res.frame_length;
  assign unit_address_o        = res.unit_address;
  assign function_code_o       = res.function_code;
  assign crc_ok_o              = res.crc_ok;
  assign exception_code_o      = res.exception_code;
  assign start_register_o      = res.start_register;
  assign read_quantity_o       = res.read_quantity;
  assign response_byte_count_o = res.response_byte_count;

endmodule
`default_nettype wire

### hw/rtl/mrfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter, front end
// Tracks the candidate window byte by byte: count, running CRC, header fields
// and CRC checks at the candidate frame lengths. Emits a window snapshot on
// the byte that marks the end of the buffer.
// ----------------------------------------------------------------------------
module mrfd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic                 window_start_i,
  input  wire logic                 buffer_end_i,
  output logic                      push_o,
  output mrfd_pkg::window_rec_t     rec_o
);

  logic        open_q, open_d;
  logic [7:0]  seen_q, seen_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_prev_q, crc_prev_d;
  logic [7:0]  unit_q, unit_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] regw_q, regw_d;
  logic [15:0] qty_q, qty_d;
  logic [7:0]  recent_q, recent_d;
  logic        reqp_q, reqp_d;
  logic        c5_q, c5_d;
  logic        c8_q, c8_d;
  logic        cr_q, cr_d;
  logic        push;

  // Window update for one accepted byte.
  always_comb begin
    logic [7:0] n_new;
    logic       match;
    n_new      = 8'd0;
    match      = 1'b0;
    push       = 1'b0;
    open_d     = open_q;
    seen_d     = seen_q;
    crc_d      = crc_q;
    crc_prev_d = crc_prev_q;
    unit_d     = unit_q;
    code_d     = code_q;
    count_d    = count_q;
    regw_d     = regw_q;
    qty_d      = qty_q;
    recent_d   = recent_q;
    reqp_d     = reqp_q;
    c5_d       = c5_q;
    c8_d       = c8_q;
    cr_d       = cr_q;
    if (accept_i) begin
      // A start flag drops any open window and opens a fresh one.
      if (window_start_i) begin
        open_d     = 1'b1;
        seen_d     = 8'd0;
        crc_d      = mrfd_pkg::CrcInit;
        crc_prev_d = mrfd_pkg::CrcInit;
        unit_d     = 8'd0;
        code_d     = 8'd0;
        count_d    = 8'd0;
        regw_d     = 16'd0;
        qty_d      = 16'd0;
        recent_d   = 8'd0;
        reqp_d     = 1'b0;
        c5_d       = 1'b0;
        c8_d       = 1'b0;
        cr_d       = 1'b0;
      end
      if (open_d) begin
        // The count saturates; bytes past that point change nothing.
        if (seen_d != mrfd_pkg::SeenMax) begin
          n_new      = seen_d + 8'd1;
          seen_d     = n_new;
          match      = (n_new >= 8'd2) && (crc_prev_d == {byte_value_i, recent_d});
          crc_prev_d = crc_d;
          crc_d      = mrfd_pkg::crc_fold(crc_d, byte_value_i);
          if (n_new == 8'd1) begin
            unit_d = byte_value_i;
          end
          if (n_new == 8'd2) begin
            code_d = byte_value_i;
            reqp_d = (byte_value_i == mrfd_pkg::FcReadHolding) ||
                     (byte_value_i == mrfd_pkg::FcReadInput);
          end
          if (n_new == 8'd3) begin
            count_d = byte_value_i;
          end
          if (n_new == 8'd4) begin
            regw_d = {count_d, byte_value_i};
          end
          if (n_new == 8'd5) begin
            qty_d = {byte_value_i, 8'd0};
            c5_d  = match;
          end
          if (n_new == 8'd6) begin
            qty_d = {qty_d[15:8], byte_value_i};
          end
          if (n_new == 8'd8) begin
            c8_d = match;
          end
          if ((n_new >= mrfd_pkg::MinJudgeLen) &&
              ({1'b0, n_new} == ({1'b0, count_d} + {1'b0, mrfd_pkg::RespOverhead}))) begin
            cr_d = match;
          end
          recent_d = byte_value_i;
        end
        // The end of the buffer closes the window and yields one item.
        if (buffer_end_i) begin
          push   = 1'b1;
          open_d = 1'b0;
        end
      end
    end
  end

  // Window state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      seen_q     <= 8'd0;
      crc_q      <= mrfd_pkg::CrcInit;
      crc_prev_q <= mrfd_pkg::CrcInit;
      unit_q     <= 8'd0;
      code_q     <= 8'd0;
      count_q    <= 8'd0;
      regw_q     <= 16'd0;
      qty_q      <= 16'd0;
      recent_q   <= 8'd0;
      reqp_q     <= 1'b0;
      c5_q       <= 1'b0;
      c8_q       <= 1'b0;
      cr_q       <= 1'b0;
    end else begin
      open_q     <= open_d;
      seen_q     <= seen_d;
      crc_q      <= crc_d;
      crc_prev_q <= crc_prev_d;
      unit_q     <= unit_d;
      code_q     <= code_d;
      count_q    <= count_d;
      regw_q     <= regw_d;
      qty_q      <= qty_d;
      recent_q   <= recent_d;
      reqp_q     <= reqp_d;
      c5_q       <= c5_d;
      c8_q       <= c8_d;
      cr_q       <= cr_d;
    end
  end

  // Snapshot of the window as it stands after this byte.
  assign push_o             = push;
  assign rec_o.seen         = seen_d;
  assign rec_o.unit         = unit_d;
  assign rec_o.code         = code_d;
  assign rec_o.count        = count_d;
  assign rec_o.reg_word     = regw_d;
  assign rec_o.qty_word     = qty_d;
  assign rec_o.req_possible = reqp_d;
  assign rec_o.crc_at5      = c5_d;
  assign rec_o.crc_at8      = c8_d;
  assign rec_o.crc_atresp   = cr_d;

endmodule
`default_nettype wire

### hw/rtl/mrfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter, window queue
// Small first-in first-out buffer of closed window snapshots between the
// front end and the judging back end.
// ----------------------------------------------------------------------------
module mrfd_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire mrfd_pkg::window_rec_t push_rec_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output mrfd_pkg::window_rec_t      rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mrfd_pkg::window_rec_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rec_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mrfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter, back end
// Holds the two limit registers, judges each window snapshot against them
// and keeps the result item in an output register until it is taken.
// ----------------------------------------------------------------------------
module mrfd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mrfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          q_valid_i,
  input  wire mrfd_pkg::window_rec_t         q_rec_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mrfd_pkg::result_t                  res_o
);

  logic [mrfd_pkg::QtyLimW-1:0] qty_lim_q;
  logic [7:0]                   count_lim_q;
  logic                         out_valid_q;
  mrfd_pkg::result_t            res_q, res_d;
  logic                         load;

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qty_lim_q   <= mrfd_pkg::QtyLimReset;
      count_lim_q <= mrfd_pkg::CountLimReset;
    end else if (cfg_we_i) begin
      unique case (mrfd_pkg::cfg_idx_e'(cfg_idx_i))
        mrfd_pkg::CFG_MAX_QTY: qty_lim_q   <= cfg_wdata_i[mrfd_pkg::QtyLimW-1:0];
        mrfd_pkg::CFG_MAX_BC:  count_lim_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Frame judgement: exception first, then request, then response.
  always_comb begin
    logic       is_exc_code;
    logic       exc_ok;
    logic       req_ok;
    logic       resp_ok;
    logic [8:0] resp_len;
    is_exc_code = (q_rec_i.code == mrfd_pkg::FcExcHolding) ||
                  (q_rec_i.code == mrfd_pkg::FcExcInput);
    resp_len    = {1'b0, q_rec_i.count} + {1'b0, mrfd_pkg::RespOverhead};
    exc_ok      = is_exc_code && (q_rec_i.seen >= mrfd_pkg::ExcLen) && q_rec_i.crc_at5;
    req_ok      = q_rec_i.req_possible && (q_rec_i.seen >= mrfd_pkg::ReqLen) &&
                  (q_rec_i.qty_word != 16'd0) &&
                  (q_rec_i.qty_word <= {{(16 - mrfd_pkg::QtyLimW){1'b0}}, qty_lim_q});
    resp_ok     = q_rec_i.req_possible && (q_rec_i.count >= 8'd2) && !q_rec_i.count[0] &&
                  (q_rec_i.count <= count_lim_q) && ({1'b0, q_rec_i.seen} >= resp_len);
    res_d = '0;
    res_d.outcome = mrfd_pkg::OUT_NONE;
    if (q_rec_i.seen >= mrfd_pkg::MinJudgeLen) begin
      if (exc_ok) begin
        res_d.outcome        = mrfd_pkg::OUT_EXCEPTION;
        res_d.frame_length   = mrfd_pkg::ExcLen;
        res_d.crc_ok         = 1'b1;
        res_d.exception_code = q_rec_i.count;
      end else if (req_ok) begin
        res_d.outcome        = mrfd_pkg::OUT_REQUEST;
        res_d.frame_length   = mrfd_pkg::ReqLen;
        res_d.crc_ok         = q_rec_i.crc_at8;
        res_d.start_register = q_rec_i.reg_word;
        res_d.read_quantity  = q_rec_i.qty_word;
      end else if (resp_ok) begin
        res_d.outcome             = mrfd_pkg::OUT_RESPONSE;
        res_d.frame_length        = resp_len[7:0];
        res_d.crc_ok              = q_rec_i.crc_atresp;
        res_d.response_byte_count = q_rec_i.count;
      end
      if (exc_ok || req_ok || resp_ok) begin
        res_d.unit_address  = q_rec_i.unit;
        res_d.function_code = q_rec_i.code;
      end
    end
  end

  // The output register takes a new item whenever it is empty or being taken.
  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

### hw/rtl/mrfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame delimiter checker
// Port-level assertions on the result items, bound to the top level.
// ----------------------------------------------------------------------------
module mrfd_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         out_valid_o,
  input  wire logic         out_stall_i,
  input  wire logic [1:0]   outcome_o,
  input  wire logic [7:0]   frame_length_o,
  input  wire logic [7:0]   unit_address_o,
  input  wire logic [7:0]   function_code_o,
  input  wire logic         crc_ok_o,
  input  wire logic [15:0]  start_register_o,
  input  wire logic [15:0]  read_quantity_o,
  input  wire logic [7:0]   response_byte_count_o
);

  // A stalled result item holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o) &&
      $stable(frame_length_o) && $stable(start_register_o))
    else $error("result item changed while stalled");

  // A window without a frame reports nothing but zeros.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == mrfd_pkg::OUT_NONE) |->
      (frame_length_o == 8'd0) && (unit_address_o == 8'd0) &&
      (function_code_o == 8'd0) && !crc_ok_o && (read_quantity_o == 16'd0))
    else $error("no-frame result carries data");

  // An exception always has five bytes and a good CRC.
  a_exc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == mrfd_pkg::OUT_EXCEPTION) |->
      (frame_length_o == mrfd_pkg::ExcLen) && crc_ok_o &&
      ((function_code_o == mrfd_pkg::FcExcHolding) ||
       (function_code_o == mrfd_pkg::FcExcInput)))
    else $error("malformed exception result");

  // A response length follows from an even, non-zero byte count.
  a_resp_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == mrfd_pkg::OUT_RESPONSE) |->
      (frame_length_o == response_byte_count_o + mrfd_pkg::RespOverhead) &&
      !response_byte_count_o[0] && (response_byte_count_o != 8'd0))
    else $error("malformed response result");

endmodule

bind modbus_rtu_frame_delimiter mrfd_checker u_mrfd_checker (.*);
`default_nettype wire
